@@ rtl/core/ndbo_pkg.sv @@
// Shared types and constants for the n-dimensional block odometer.
// Used by ndbo_div and nd_block_odometer_iterator; no dependencies.
package ndbo_pkg;

  // Default parameter values
  localparam int MAX_RANK_DEF = 4;
  localparam int DIM_BITS_DEF = 16;

  // Fixed field and register widths
  localparam int BUF_W       = 32;
  localparam int EB_W        = 16;
  localparam int RANK_W      = 3;
  localparam int PACK_W      = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int PROD_W      = 33;  // byte products, saturating at 2^32
  localparam int IDX_OUT_W   = 2;
  localparam int COORD_W     = 16;
  localparam int TOTAL_W     = 32;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_BYTES  = 3'd0,
    CFG_ELEMENT_BYTES = 3'd1,
    CFG_RANK_USED     = 3'd2,
    CFG_CHUNKED_MODE  = 3'd3,
    CFG_DIM_SIZES     = 3'd4,
    CFG_CHUNK_SIZES   = 3'd5
  } cfg_reg_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_CHUNK_BIG = 2'd1,
    ST_NO_FIT    = 2'd2
  } status_t;

  // Register reset values
  localparam logic [BUF_W-1:0]  RST_BUFFER_BYTES  = 32'd65536;
  localparam logic [EB_W-1:0]   RST_ELEMENT_BYTES = 16'd1;
  localparam logic [RANK_W-1:0] RST_RANK_USED     = 3'd1;
  localparam logic [PACK_W-1:0] RST_PACKED_SIZES  = 64'h0001_0001_0001_0001;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

@@ rtl/core/ndbo_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on ndbo_pkg for the status struct and the default width.
module ndbo_div #(
  parameter int W = ndbo_pkg::BUF_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [W-1:0]       dividend,
  input  logic [W-1:0]       divisor,
  output ndbo_pkg::div_sts_t sts,
  output logic [W-1:0]       quot,
  output logic [W-1:0]       rem
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic          done;
  logic [W-1:0]  q;
  logic [W-1:0]  r;
  logic [W-1:0]  dv;
  logic [W:0]    rt;
  logic [W:0]    rsub;
  logic          ge;

  // trial subtract of the shifted partial remainder
  always_comb begin
    rt   = {r, q[W-1]};
    ge   = rt >= {1'b0, dv};
    rsub = rt - {1'b0, dv};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && cnt == '0) begin
        cnt <= CW'(W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && cnt == '0) begin
      q  <= dividend;
      r  <= '0;
      dv <= divisor;
    end else if (cnt != '0) begin
      r <= ge ? rsub[W-1:0] : rt[W-1:0];
      q <= {q[W-2:0], ge};
    end
  end

  assign sts.busy = cnt != '0;
  assign sts.done = done;
  assign quot     = q;
  assign rem      = r;

endmodule

@@ rtl/core/nd_block_odometer_iterator.sv @@
// Channel   Dir  Group         Content
// request   in   s_t*          restart flag
// result    out  m_t*, tlast   one item per dimension (one on an error), tlast on the final one
// config    in   cfg_*         write enable, register index, data
//
// Top level of the block odometer; uses ndbo_pkg and ndbo_div.
// One request at a time: s_tready is high only while no request is in work.
// A plain advance steps the odometer, then forms the element total on the shared
// multiplier, one dimension per multiply, plus r result transfers, r being the rank.
// A restart first walks the plan, one dimension at a time through the multiplier,
// and in contiguous mode runs up to two divisions on the shared divider.
// Synchronous reset clears control state; no clearing pass. Output stalls hold.
module nd_block_odometer_iterator #(
  parameter int MAX_RANK = ndbo_pkg::MAX_RANK_DEF,
  parameter int DIM_BITS = ndbo_pkg::DIM_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [ndbo_pkg::IN_TDATA_W-1:0]      s_tdata,   // [0] restart
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [1:0] dim_index, [17:2] start_index, [33:18] count_len,
  // [65:34] elements_total, [66] done_res, [68:67] status
  output logic [ndbo_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                 m_tlast,
  input  logic                                 cfg_we,
  input  logic [ndbo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ndbo_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int RW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int RKW = $clog2(MAX_RANK + 1);
  localparam int WW  = DIM_BITS + 1;
  localparam int PW  = ndbo_pkg::PROD_W;
  localparam int BW  = ndbo_pkg::BUF_W;
  localparam int MW  = PW + DIM_BITS;
  localparam logic [PW-1:0] CAP = {1'b1, {BW{1'b0}}};

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_CPMUL = 12'b0000_0000_0010,
    S_CPCMP = 12'b0000_0000_0100,
    S_DIV1  = 12'b0000_0000_1000,
    S_DIV2  = 12'b0000_0001_0000,
    S_CHMUL = 12'b0000_0010_0000,
    S_CHACC = 12'b0000_0100_0000,
    S_FILL  = 12'b0000_1000_0000,
    S_ADV   = 12'b0001_0000_0000,
    S_TTMUL = 12'b0010_0000_0000,
    S_TTACC = 12'b0100_0000_0000,
    S_EMIT  = 12'b1000_0000_0000
  } state_t;

  // configuration registers
  logic [BW-1:0]                    buffer_bytes;
  logic [ndbo_pkg::EB_W-1:0]        element_bytes;
  logic [ndbo_pkg::RANK_W-1:0]      rank_used;
  logic                             chunked_mode;
  logic [ndbo_pkg::PACK_W-1:0]      dim_sizes_packed;
  logic [ndbo_pkg::PACK_W-1:0]      chunk_sizes_packed;

  // walk state
  state_t                state;
  logic                  first_pending;
  logic                  more_blocks;
  logic [RW-1:0]         split_dim;
  logic [DIM_BITS-1:0]   rows_per_block;
  logic [DIM_BITS-1:0]   full_blocks;
  logic [DIM_BITS-1:0]   leftover_rows;
  logic [DIM_BITS-1:0]   block_counter;
  logic [DIM_BITS-1:0]   step_amount;
  logic [DIM_BITS-1:0]   start_v [MAX_RANK];
  logic [DIM_BITS-1:0]   count_v [MAX_RANK];
  ndbo_pkg::status_t     error_code;

  // sequencer
  logic [RKW-1:0]        rk;
  logic [RKW-1:0]        ci;
  logic [RKW-1:0]        ci_m1;
  logic [RW-1:0]         k;
  logic [PW-1:0]         cprod;
  logic [ndbo_pkg::TOTAL_W-1:0] tot;
  logic [RKW-1:0]        eff_rank;
  logic [3:0]            ru4;

  // shared multiplier
  logic [PW-1:0]         mul_a;
  logic [DIM_BITS-1:0]   mul_b;
  logic [MW-1:0]         mres;

  // shared divider
  logic                  div_start;
  logic [BW-1:0]         div_dividend;
  logic [BW-1:0]         div_divisor;
  ndbo_pkg::div_sts_t    div_sts;
  logic [BW-1:0]         div_quot;
  logic [BW-1:0]         div_rem;

  // field views and next values
  logic [DIM_BITS-1:0]   dl [MAX_RANK];
  logic [DIM_BITS-1:0]   cl [MAX_RANK];
  logic [DIM_BITS-1:0]   a_start [MAX_RANK];
  logic [DIM_BITS-1:0]   a_count [MAX_RANK];
  logic [DIM_BITS-1:0]   f_count [MAX_RANK];
  logic                  a_more;

  // result fields
  logic                  err;
  logic                  o_last;
  logic [ndbo_pkg::IDX_OUT_W-1:0] o_dim;
  logic [ndbo_pkg::COORD_W-1:0]   o_start;
  logic [ndbo_pkg::COORD_W-1:0]   o_count;
  logic [ndbo_pkg::TOTAL_W-1:0]   o_total;
  logic                  o_done;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes       <= ndbo_pkg::RST_BUFFER_BYTES;
      element_bytes      <= ndbo_pkg::RST_ELEMENT_BYTES;
      rank_used          <= ndbo_pkg::RST_RANK_USED;
      chunked_mode       <= 1'b0;
      dim_sizes_packed   <= ndbo_pkg::RST_PACKED_SIZES;
      chunk_sizes_packed <= ndbo_pkg::RST_PACKED_SIZES;
    end else if (cfg_we) begin
      case (cfg_index)
        ndbo_pkg::CFG_BUFFER_BYTES:  buffer_bytes  <= cfg_data[BW-1:0];
        ndbo_pkg::CFG_ELEMENT_BYTES: element_bytes <= cfg_data[ndbo_pkg::EB_W-1:0];
        ndbo_pkg::CFG_RANK_USED:     rank_used     <= cfg_data[ndbo_pkg::RANK_W-1:0];
        ndbo_pkg::CFG_CHUNKED_MODE:  chunked_mode  <= cfg_data[0];
        ndbo_pkg::CFG_DIM_SIZES:     dim_sizes_packed   <= cfg_data;
        ndbo_pkg::CFG_CHUNK_SIZES:   chunk_sizes_packed <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-dimension lengths out of the packed registers
  for (genvar g = 0; g < MAX_RANK; g++) begin : g_fld
    if (g * DIM_BITS < ndbo_pkg::PACK_W) begin : g_in
      assign dl[g] = DIM_BITS'(dim_sizes_packed >> (g * DIM_BITS));
      assign cl[g] = DIM_BITS'(chunk_sizes_packed >> (g * DIM_BITS));
    end else begin : g_out
      assign dl[g] = '0;
      assign cl[g] = '0;
    end
  end

  // rank clamped into 1..MAX_RANK
  always_comb begin
    ru4 = {1'b0, rank_used};
    if (ru4 == 4'd0) begin
      eff_rank = RKW'(1);
    end else if (ru4 > 4'(MAX_RANK)) begin
      eff_rank = RKW'(MAX_RANK);
    end else begin
      eff_rank = RKW'(ru4);
    end
  end

  assign ci_m1 = ci - 1'b1;

  // multiplier operand select
  always_comb begin
    if (state == S_CPMUL) begin
      mul_a = cprod;
      mul_b = dl[ci_m1[RW-1:0]];
    end else if (state == S_CHMUL) begin
      mul_a = cprod;
      mul_b = cl[ci[RW-1:0]];
    end else begin
      mul_a = {1'b0, tot};
      mul_b = count_v[ci[RW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    mres <= MW'(mul_a) * MW'(mul_b);
  end

  // divider: buffer by bytes per row, then split length by rows
  always_comb begin
    if (state == S_DIV1) begin
      div_dividend = BW'(dl[split_dim]);
      div_divisor  = div_quot;
      div_start    = div_sts.done && div_quot != '0;
    end else begin
      div_dividend = buffer_bytes;
      div_divisor  = cprod[BW-1:0];
      div_start    = state == S_CPCMP && mres > MW'(buffer_bytes);
    end
  end

  ndbo_div #(.W(BW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // odometer step with carry walk
  always_comb begin
    logic [WW-1:0] w [MAX_RANK];
    logic [WW-1:0] n;
    logic [WW-1:0] room;
    n    = '0;
    room = '0;
    for (int id = 0; id < MAX_RANK; id++) begin
      w[id]       = WW'(start_v[id]);
      a_start[id] = start_v[id];
      a_count[id] = count_v[id];
    end
    a_more = 1'b0;
    if (chunked_mode) begin
      for (int id = 0; id < MAX_RANK; id++) begin
        if (RKW'(id) == rk - 1'b1) begin
          w[id] = w[id] + WW'(cl[id]);
        end
      end
      for (int id = MAX_RANK - 1; id > 0; id--) begin
        if (RKW'(id) < rk && w[id] >= WW'(dl[id])) begin
          w[id - 1] = w[id - 1] + WW'(cl[id - 1]);
          w[id]     = '0;
        end
      end
      a_more = w[0] < WW'(dl[0]);
      for (int id = 0; id < MAX_RANK; id++) begin
        if (RKW'(id) < rk) begin
          n    = (cl[id] <= dl[id]) ? WW'(cl[id]) : WW'(dl[id]);
          room = (w[id] < WW'(dl[id])) ? WW'(dl[id]) - w[id] : '0;
          if (room < n) begin
            n = room;
          end
          a_count[id] = DIM_BITS'(n);
          a_start[id] = DIM_BITS'(w[id]);
        end
      end
    end else if (step_amount != '0) begin
      for (int id = 0; id < MAX_RANK; id++) begin
        if (RW'(id) == split_dim) begin
          w[id] = w[id] + WW'(step_amount);
        end
      end
      for (int id = MAX_RANK - 1; id > 0; id--) begin
        if (RW'(id) <= split_dim && w[id] >= WW'(dl[id])) begin
          w[id - 1] = w[id - 1] + 1'b1;
          w[id]     = w[id] - WW'(dl[id]);
        end
      end
      a_more = w[0] < WW'(dl[0]);
      for (int id = 0; id < MAX_RANK; id++) begin
        a_start[id] = DIM_BITS'(w[id]);
      end
    end
  end

  // first block counts from the plan
  always_comb begin
    for (int id = 0; id < MAX_RANK; id++) begin
      f_count[id] = '0;
      if (RKW'(id) < rk) begin
        if (chunked_mode) begin
          f_count[id] = (cl[id] <= dl[id]) ? cl[id] : dl[id];
        end else if (RW'(id) < split_dim) begin
          f_count[id] = DIM_BITS'(1);
        end else if (RW'(id) == split_dim) begin
          f_count[id] = rows_per_block;
        end else begin
          f_count[id] = dl[id];
        end
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      first_pending  <= 1'b1;
      more_blocks    <= 1'b1;
      split_dim      <= '0;
      rows_per_block <= '0;
      full_blocks    <= '0;
      leftover_rows  <= '0;
      block_counter  <= '0;
      step_amount    <= '0;
      error_code     <= ndbo_pkg::ST_OK;
      rk             <= RKW'(1);
      ci             <= '0;
      k              <= '0;
      tot            <= '0;
      for (int id = 0; id < MAX_RANK; id++) begin
        start_v[id] <= '0;
        count_v[id] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            k  <= '0;
            rk <= eff_rank;
            if (s_tdata[0] || first_pending) begin
              first_pending <= 1'b0;
              more_blocks   <= 1'b1;
              error_code    <= ndbo_pkg::ST_OK;
              full_blocks   <= '0;
              leftover_rows <= '0;
              block_counter <= '0;
              cprod         <= PW'(element_bytes);
              for (int id = 0; id < MAX_RANK; id++) begin
                start_v[id] <= '0;
                count_v[id] <= '0;
              end
              if (chunked_mode) begin
                ci    <= '0;
                state <= S_CHMUL;
              end else begin
                ci    <= eff_rank;
                state <= S_CPMUL;
              end
            end else if (error_code != ndbo_pkg::ST_OK) begin
              state <= S_EMIT;
            end else if (more_blocks) begin
              state <= S_ADV;
            end else begin
              tot   <= '0;
              state <= S_EMIT;
            end
          end
        end
        // contiguous: grow the inner block while its bytes fit
        S_CPMUL: begin
          if (ci == '0) begin
            split_dim      <= '0;
            rows_per_block <= dl[0];
            step_amount    <= '0;
            state          <= S_FILL;
          end else begin
            state <= S_CPCMP;
          end
        end
        S_CPCMP: begin
          if (mres <= MW'(buffer_bytes)) begin
            cprod <= PW'(mres);
            ci    <= ci_m1;
            state <= S_CPMUL;
          end else begin
            split_dim <= ci_m1[RW-1:0];
            state     <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_sts.done) begin
            if (div_quot == '0) begin
              error_code <= ndbo_pkg::ST_NO_FIT;
              state      <= S_EMIT;
            end else begin
              rows_per_block <= DIM_BITS'(div_quot);
              step_amount    <= DIM_BITS'(div_quot);
              block_counter  <= DIM_BITS'(1);
              state          <= S_DIV2;
            end
          end
        end
        S_DIV2: begin
          if (div_sts.done) begin
            full_blocks   <= DIM_BITS'(div_quot);
            leftover_rows <= DIM_BITS'(div_rem);
            state         <= S_FILL;
          end
        end
        // chunked: saturating chunk byte product
        S_CHMUL: begin
          if (ci == rk) begin
            if (cprod > PW'(buffer_bytes)) begin
              error_code <= ndbo_pkg::ST_CHUNK_BIG;
              state      <= S_EMIT;
            end else begin
              state <= S_FILL;
            end
          end else begin
            state <= S_CHACC;
          end
        end
        S_CHACC: begin
          cprod <= (mres > MW'(CAP)) ? CAP : PW'(mres);
          ci    <= ci + 1'b1;
          state <= S_CHMUL;
        end
        S_FILL: begin
          for (int id = 0; id < MAX_RANK; id++) begin
            count_v[id] <= f_count[id];
          end
          tot   <= ndbo_pkg::TOTAL_W'(1);
          ci    <= '0;
          state <= S_TTMUL;
        end
        S_ADV: begin
          more_blocks <= a_more;
          for (int id = 0; id < MAX_RANK; id++) begin
            start_v[id] <= a_start[id];
          end
          if (chunked_mode) begin
            for (int id = 0; id < MAX_RANK; id++) begin
              count_v[id] <= a_count[id];
            end
          end else if (block_counter < full_blocks) begin
            step_amount        <= rows_per_block;
            count_v[split_dim] <= rows_per_block;
            block_counter      <= block_counter + 1'b1;
          end else if (leftover_rows != '0) begin
            count_v[split_dim] <= leftover_rows;
            step_amount        <= leftover_rows;
            block_counter      <= '0;
          end
          if (!a_more) begin
            tot   <= '0;
            state <= S_EMIT;
          end else begin
            tot   <= ndbo_pkg::TOTAL_W'(1);
            ci    <= '0;
            state <= S_TTMUL;
          end
        end
        // element total, one dimension per multiply
        S_TTMUL: begin
          state <= S_TTACC;
        end
        S_TTACC: begin
          tot <= mres[ndbo_pkg::TOTAL_W-1:0];
          if (ci == rk - 1'b1) begin
            state <= S_EMIT;
          end else begin
            ci    <= ci + 1'b1;
            state <= S_TTMUL;
          end
        end
        S_EMIT: begin
          if (m_tready) begin
            if (o_last) begin
              state <= S_IDLE;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result fields; an error gives one all-zero item with the code
  assign err     = error_code != ndbo_pkg::ST_OK;
  assign o_last  = err || (RKW'(k) == rk - 1'b1);
  assign o_dim   = err ? '0 : ndbo_pkg::IDX_OUT_W'(k);
  assign o_start = err ? '0 : ndbo_pkg::COORD_W'(start_v[k]);
  assign o_count = err ? '0 : ndbo_pkg::COORD_W'(count_v[k]);
  assign o_total = err ? '0 : tot;
  assign o_done  = err ? 1'b0 : !more_blocks;

  assign s_tready = state == S_IDLE;
  assign m_tvalid = state == S_EMIT;
  assign m_tlast  = o_last;
  assign m_tdata  = {3'b000, error_code, o_done, o_total, o_count, o_start, o_dim};

`ifndef SYNTHESIS
  // no request taken while a result is offered
  a_excl: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("request accepted while results pending");

  // an error result is always the only item of its request
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && err) |-> m_tlast)
    else $error("error result not marked last");

  // divider is only started when free
  a_div_free: assert property (@(posedge clk) disable iff (rst) div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  // after the final transfer the block takes requests again
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not ready after last transfer");
`endif

endmodule

@@ verif/nd_block_odometer_checker.sv @@
// Checker for the block odometer: predicts each result item from the request and
// configuration transfers it watches, and compares the result channel against it.
// Depends on ndbo_pkg only.
`timescale 1ns / 100ps

module nd_block_odometer_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [ndbo_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [ndbo_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [ndbo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ndbo_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               pending,
  output int                               blocks_checked
);

  typedef struct packed {
    logic [1:0]  dim;
    logic [15:0] start;
    logic [15:0] count;
    logic [31:0] total;
    logic        done;
    logic [1:0]  status;
    logic        last;
  } block_result_t;

  block_result_t expected_blocks[$];

  // Shadow of the configuration registers
  logic [31:0] buf_bytes;
  logic [15:0] elem_bytes;
  logic [2:0]  rank_reg;
  logic        chunked;
  logic [63:0] dim_sizes;
  logic [63:0] chunk_sizes;

  // Shadow of the walk state
  logic        first_pend, more_blk;
  logic [1:0]  split, err;
  logic [15:0] rows_blk, full_blk, left_rows, blk_cnt, step_amt;
  logic [15:0] start_v[4];
  logic [15:0] count_v[4];

  assign pending = expected_blocks.size();

  function automatic longint unsigned dlen(int i);
    return (dim_sizes >> (16 * i)) & 64'hFFFF;
  endfunction

  function automatic longint unsigned clen(int i);
    return (chunk_sizes >> (16 * i)) & 64'hFFFF;
  endfunction

  // Plan from the live registers and set up the first block; returns a status code
  function automatic logic [1:0] plan_first_block(int r);
    longint unsigned prod, d, rows, nr, c;
    int s, i, k;
    for (k = 0; k < 4; k++) begin
      start_v[k] = '0;
      count_v[k] = '0;
    end
    if (!chunked) begin
      prod = elem_bytes;
      s = r - 1;
      i = r;
      // grow the fitting inner region outward
      while (i > 0) begin
        d = dlen(i - 1);
        if (prod * d <= buf_bytes) begin
          prod = prod * d;
          s--;
          i--;
        end else break;
      end
      full_blk = '0;
      left_rows = '0;
      blk_cnt = '0;
      if (i > 0) begin
        rows = (prod != 0) ? buf_bytes / prod : 0;
        if (rows == 0) return ndbo_pkg::ST_NO_FIT;
        d = dlen(s);
        nr = d / rows;
        split = s[1:0];
        rows_blk = rows[15:0];
        full_blk = nr[15:0];
        left_rows = 16'(d - nr * rows);
        blk_cnt = 16'd1;
        step_amt = rows[15:0];
      end else begin
        split = '0;
        rows_blk = 16'(dlen(0));
        step_amt = '0;
      end
      for (k = 0; k < r; k++) begin
        if (k < split) count_v[k] = 16'd1;
        else if (k == split) count_v[k] = rows_blk;
        else count_v[k] = 16'(dlen(k));
      end
    end else begin
      prod = elem_bytes;
      for (k = 0; k < r; k++) begin
        prod = prod * clen(k);
        if (prod > 64'h1_0000_0000) prod = 64'h1_0000_0000;
      end
      if (prod > buf_bytes) return ndbo_pkg::ST_CHUNK_BIG;
      for (k = 0; k < r; k++) begin
        c = clen(k);
        d = dlen(k);
        count_v[k] = 16'((c <= d) ? c : d);
      end
    end
    return ndbo_pkg::ST_OK;
  endfunction

  // Row-block odometer step with carry; returns whether blocks remain
  function automatic bit advance_rows();
    longint unsigned w[4];
    longint unsigned d;
    int s, id;
    bit more;
    for (id = 0; id < 4; id++) w[id] = start_v[id];
    s = split;
    more = 1'b1;
    if (step_amt == 0) begin
      more = 1'b0;
    end else begin
      w[s] = w[s] + step_amt;
      for (id = s; id > 0; id--) begin
        d = dlen(id);
        if (w[id] >= d) begin
          w[id-1] = w[id-1] + 1;
          w[id] = w[id] - d;
        end
      end
      more = w[0] < dlen(0);
      for (id = 0; id < 4; id++) start_v[id] = w[id][15:0];
    end
    if (blk_cnt < full_blk) begin
      step_amt = rows_blk;
      count_v[s] = rows_blk;
      blk_cnt = blk_cnt + 16'd1;
    end else if (left_rows > 0) begin
      count_v[s] = left_rows;
      step_amt = left_rows;
      blk_cnt = '0;
    end
    return more;
  endfunction

  // Chunk-by-chunk step, clipping at the dimension edges
  function automatic bit advance_chunks(int r);
    longint unsigned w[4];
    longint unsigned c, d, n, room;
    int id;
    bit more;
    for (id = 0; id < 4; id++) w[id] = start_v[id];
    w[r-1] = w[r-1] + clen(r - 1);
    for (id = r - 1; id > 0; id--) begin
      if (w[id] >= dlen(id)) begin
        w[id-1] = w[id-1] + clen(id - 1);
        w[id] = 0;
      end
    end
    more = w[0] < dlen(0);
    for (id = 0; id < r; id++) begin
      c = clen(id);
      d = dlen(id);
      n = (c <= d) ? c : d;
      room = (w[id] < d) ? d - w[id] : 0;
      if (room < n) n = room;
      count_v[id] = n[15:0];
      start_v[id] = w[id][15:0];
    end
    return more;
  endfunction

  // Work out the results of one request and queue them
  function automatic void predict_blocks(bit restart);
    int r, i;
    longint unsigned total;
    bit done_f;
    block_result_t res;
    r = rank_reg;
    if (r < 1) r = 1;
    if (r > 4) r = 4;
    if (restart) first_pend = 1'b1;
    if (first_pend) begin
      first_pend = 1'b0;
      more_blk = 1'b1;
      err = plan_first_block(r);
    end else if (err == ndbo_pkg::ST_OK && more_blk) begin
      more_blk = chunked ? advance_chunks(r) : advance_rows();
    end
    if (err != ndbo_pkg::ST_OK) begin
      res = '{dim: 0, start: 0, count: 0, total: 0, done: 0, status: err, last: 1};
      expected_blocks.push_back(res);
      return;
    end
    done_f = !more_blk;
    total = 1;
    for (i = 0; i < r; i++) total = total * count_v[i];
    if (done_f) total = 0;
    for (i = 0; i < r; i++) begin
      res.dim = i[1:0];
      res.start = start_v[i];
      res.count = count_v[i];
      res.total = total[31:0];
      res.done = done_f;
      res.status = ndbo_pkg::ST_OK;
      res.last = (i == r - 1);
      expected_blocks.push_back(res);
    end
  endfunction

  // Watch the channels
  always @(posedge clk) begin
    block_result_t exp_r, got;
    if (rst) begin
      buf_bytes <= ndbo_pkg::RST_BUFFER_BYTES;
      elem_bytes <= ndbo_pkg::RST_ELEMENT_BYTES;
      rank_reg <= ndbo_pkg::RST_RANK_USED;
      chunked <= 1'b0;
      dim_sizes <= ndbo_pkg::RST_PACKED_SIZES;
      chunk_sizes <= ndbo_pkg::RST_PACKED_SIZES;
      first_pend = 1'b1;
      more_blk = 1'b1;
      split = '0;
      err = '0;
      rows_blk = '0;
      full_blk = '0;
      left_rows = '0;
      blk_cnt = '0;
      step_amt = '0;
      for (int k = 0; k < 4; k++) begin
        start_v[k] = '0;
        count_v[k] = '0;
      end
      expected_blocks.delete();
      fail_count <= 0;
      blocks_checked <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (ndbo_pkg::cfg_reg_t'(cfg_index))
          ndbo_pkg::CFG_BUFFER_BYTES:  buf_bytes <= cfg_data[31:0];
          ndbo_pkg::CFG_ELEMENT_BYTES: elem_bytes <= cfg_data[15:0];
          ndbo_pkg::CFG_RANK_USED:     rank_reg <= cfg_data[2:0];
          ndbo_pkg::CFG_CHUNKED_MODE:  chunked <= cfg_data[0];
          ndbo_pkg::CFG_DIM_SIZES:     dim_sizes <= cfg_data;
          ndbo_pkg::CFG_CHUNK_SIZES:   chunk_sizes <= cfg_data;
          default: ;
        endcase
      end
      // result transfer
      if (m_tvalid && m_tready) begin
        got.dim = m_tdata[1:0];
        got.start = m_tdata[17:2];
        got.count = m_tdata[33:18];
        got.total = m_tdata[65:34];
        got.done = m_tdata[66];
        got.status = m_tdata[68:67];
        got.last = m_tlast;
        blocks_checked <= blocks_checked + 1;
        if (expected_blocks.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: unexpected result dim=%0d start=%0d count=%0d total=%0d",
                   $time, got.dim, got.start, got.count, got.total);
        end else begin
          exp_r = expected_blocks.pop_front();
          if (got !== exp_r) begin
            fail_count <= fail_count + 1;
            $display("%0t: result mismatch", $time);
            $display("  expected dim=%0d start=%0d count=%0d total=%0d done=%0d st=%0d last=%0d",
                     exp_r.dim, exp_r.start, exp_r.count, exp_r.total, exp_r.done,
                     exp_r.status, exp_r.last);
            $display("  actual   dim=%0d start=%0d count=%0d total=%0d done=%0d st=%0d last=%0d",
                     got.dim, got.start, got.count, got.total, got.done,
                     got.status, got.last);
          end
        end
      end
      // request transfer
      if (s_tvalid && s_tready) predict_blocks(s_tdata[0]);
    end
  end

endmodule

@@ verif/tb_nd_block_odometer_iterator.sv @@
// Testbench top for nd_block_odometer_iterator: clock, reset, request and register
// stimulus, result back-pressure and the verdict. Uses ndbo_pkg and the checker.
`timescale 1ns / 100ps

module tb_nd_block_odometer_iterator;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 80;

  logic                             clk, rst;
  logic                             s_tvalid, s_tready;
  logic [ndbo_pkg::IN_TDATA_W-1:0]  s_tdata;
  logic                             m_tvalid, m_tready, m_tlast;
  logic [ndbo_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             cfg_we;
  logic [ndbo_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [ndbo_pkg::CFG_DATA_W-1:0]  cfg_data;

  int  fail_count, pending, blocks_checked;
  int  requests_sent, random_sent, stall_left, idle_cycles;
  bit  quiet_tail;

  nd_block_odometer_iterator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  nd_block_odometer_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .blocks_checked(blocks_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result-side back-pressure in random bursts
  initial begin
    m_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (quiet_tail) begin
        m_tready = 1'b1;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        stall_left = $urandom_range(1, 15) - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(ndbo_pkg::cfg_reg_t idx, logic [63:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Let all outstanding results drain before touching registers
  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic load_cfg(logic [31:0] bytes_cap, logic [15:0] elem, logic [2:0] rank,
                          logic chunk_walk, logic [63:0] dims, logic [63:0] chunks);
    wait_idle();
    write_reg(ndbo_pkg::CFG_BUFFER_BYTES, {32'd0, bytes_cap});
    write_reg(ndbo_pkg::CFG_ELEMENT_BYTES, {48'd0, elem});
    write_reg(ndbo_pkg::CFG_RANK_USED, {61'd0, rank});
    write_reg(ndbo_pkg::CFG_CHUNKED_MODE, {63'd0, chunk_walk});
    write_reg(ndbo_pkg::CFG_DIM_SIZES, dims);
    write_reg(ndbo_pkg::CFG_CHUNK_SIZES, chunks);
  endtask

  // One request transfer, with an optional random gap ahead of it
  task automatic send_request(bit restart);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {7'd0, restart};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
    requests_sent++;
  endtask

  function automatic logic [15:0] rand_len(int hi);
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, hi));
    endcase
  endfunction

  initial begin
    logic [31:0] bytes_cap;
    logic [15:0] elem;
    logic [2:0]  rank;
    int          n;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = ndbo_pkg::CFG_BUFFER_BYTES;
    cfg_data = '0;
    quiet_tail = 1'b0;
    requests_sent = 0;
    random_sent = 0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Reset registers: first step without restart, whole variable fits, then done
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);

    // Row blocks with leftover and carry into the outer dimension
    load_cfg(32'd64, 16'd4, 3'd3, 1'b0, {16'd0, 16'd3, 16'd6, 16'd5},
             ndbo_pkg::RST_PACKED_SIZES);
    send_request(1'b1);
    repeat (7) send_request(1'b0);

    // Element larger than the buffer: error repeats
    load_cfg(32'd1, 16'hFFFF, 3'd2, 1'b0, {32'd0, 16'd4, 16'd4},
             ndbo_pkg::RST_PACKED_SIZES);
    send_request(1'b1);
    send_request(1'b0);

    // Chunked walk with clipping at the edges
    load_cfg(32'hFFFF_FFFF, 16'd1, 3'd2, 1'b1, {32'd0, 16'd7, 16'd5}, {32'd0, 16'd3, 16'd2});
    send_request(1'b1);
    repeat (6) send_request(1'b0);

    // Chunk bytes over the buffer
    load_cfg(32'd5, 16'd1, 3'd2, 1'b1, {32'd0, 16'd7, 16'd5}, {32'd0, 16'd3, 16'd2});
    send_request(1'b1);
    send_request(1'b0);

    // Zero chunk length in the outer dimension
    load_cfg(32'd100, 16'd1, 3'd2, 1'b1, {32'd0, 16'd4, 16'd3}, {32'd0, 16'd2, 16'd0});
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);

    // Rank below and above range, widest sizes
    load_cfg(32'hFFFF_FFFF, 16'hFFFF, 3'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
             64'hFFFF_FFFF_FFFF_FFFF);
    send_request(1'b1);
    send_request(1'b0);
    load_cfg(32'hFFFF_FFFF, 16'hFFFF, 3'd7, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
             ndbo_pkg::RST_PACKED_SIZES);
    send_request(1'b1);
    send_request(1'b0);

    // Random phases: a fresh setting, then mostly a walk from a restart
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: bytes_cap = $urandom;
        1: bytes_cap = 32'hFFFF_FFFF;
        default: bytes_cap = $urandom_range(1, 300);
      endcase
      elem = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
                                         : 16'($urandom_range(1, 8));
      rank = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                         : 3'($urandom_range(1, 4));
      load_cfg(bytes_cap, elem, rank, 1'($urandom),
               {rand_len(6), rand_len(6), rand_len(6), rand_len(6)},
               {rand_len(4), rand_len(4), rand_len(4), rand_len(4)});
      send_request($urandom_range(0, 9) != 0);
      n = $urandom_range(4, 14);
      repeat (n) send_request($urandom_range(0, 7) == 0);
      random_sent += n + 1;
      if (random_sent >= RANDOM_ITEMS - 20) quiet_tail = 1'b1;
    end

    // Drain, then allow for the longest restart latency
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("Sent %0d requests over several register settings; %0d results checked.",
             requests_sent, blocks_checked);
    $display("Covered contiguous and chunked walks, both error codes and rank clamping.");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/ndbo_pkg.sv
rtl/core/ndbo_div.sv
rtl/core/nd_block_odometer_iterator.sv
verif/nd_block_odometer_checker.sv
verif/tb_nd_block_odometer_iterator.sv
